/* sv/aalu_pkg.sv */
// Package for the accumulator ALU: operation codes, flag layout and the
// transaction payload types. No dependencies.
package aalu_pkg;

  localparam logic [4:0] KIND_ADD       = 5'd0;
  localparam logic [4:0] KIND_ADC       = 5'd1;
  localparam logic [4:0] KIND_SUB       = 5'd2;
  localparam logic [4:0] KIND_SBB       = 5'd3;
  localparam logic [4:0] KIND_AND       = 5'd4;
  localparam logic [4:0] KIND_XOR       = 5'd5;
  localparam logic [4:0] KIND_OR        = 5'd6;
  localparam logic [4:0] KIND_CMP       = 5'd7;
  localparam logic [4:0] KIND_INC       = 5'd8;
  localparam logic [4:0] KIND_DEC       = 5'd9;
  localparam logic [4:0] KIND_DAA       = 5'd10;
  localparam logic [4:0] KIND_RLC       = 5'd11;
  localparam logic [4:0] KIND_RRC       = 5'd12;
  localparam logic [4:0] KIND_RAL       = 5'd13;
  localparam logic [4:0] KIND_RAR       = 5'd14;
  localparam logic [4:0] KIND_CMA       = 5'd15;
  localparam logic [4:0] KIND_CMC       = 5'd16;
  localparam logic [4:0] KIND_STC       = 5'd17;
  localparam logic [4:0] KIND_PAIR_ADD  = 5'd18;
  localparam logic [4:0] KIND_LOAD_ACC  = 5'd19;
  localparam logic [4:0] KIND_LOAD_FLAG = 5'd20;

  localparam logic [7:0] DAA_ADJ_LO = 8'h06;
  localparam logic [7:0] DAA_ADJ_HI = 8'h60;

  typedef struct packed {
    logic s;
    logic z;
    logic ac;
    logic p;
    logic cy;
  } flags_t;

  typedef struct packed {
    logic [4:0]  kind;
    logic [7:0]  operand;
    logic [15:0] pair_left;
    logic [15:0] pair_right;
  } in_t;

  typedef struct packed {
    logic [7:0]  acc_out;
    logic [7:0]  status_word;
    logic [7:0]  byte_result;
    logic [15:0] pair_sum;
  } out_t;

  // Pack flags as S Z 0 AC 0 P 1 CY.
  function automatic logic [7:0] status_of(flags_t f);
    return {f.s, f.z, 1'b0, f.ac, 1'b0, f.p, 1'b1, f.cy};
  endfunction

endpackage

/* sv/accumulator_alu_with_flags.sv */
// Accumulator ALU with sign, zero, auxiliary-carry, parity and carry flags.
// Depends on aalu_pkg for operation codes, flag layout and payload types.
//
//   channel  | direction | handshake             | payload
//   ---------+-----------+-----------------------+--------------------------
//   in       | input     | in_valid / in_ready   | in_data  (aalu_pkg::in_t)
//   out      | output    | out_valid / out_ready | out_data (aalu_pkg::out_t)
//
// One transaction per cycle sustained while out_ready is high; each result
// passes through the input register, then the result register.
// Accumulator and flags update when a transaction moves into the result
// register, so the next transaction sees them with no gap.
// Reset (rst, synchronous) clears accumulator, flags and both valid bits.
// A stalled result holds the input register; in_ready drops only while both
// stages are full and out_ready is low.
module accumulator_alu_with_flags (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  aalu_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output aalu_pkg::out_t  out_data
);
  import aalu_pkg::*;

  logic   s1_valid;
  in_t    s1;
  logic   advance;
  logic [7:0] acc;
  flags_t flags;
  logic [7:0] acc_next;
  flags_t flags_next;
  logic [7:0] byte_next;
  logic [15:0] psum_next;

  logic [8:0] add_sum;
  logic [4:0] add_nib;
  logic [8:0] sub_diff;
  logic [4:0] sub_nib;
  logic       cin;
  logic [16:0] pair_full;
  logic [3:0] daa_hi;
  logic [3:0] daa_lo;
  logic       daa_lo_adj;
  logic       daa_hi_adj;
  logic [7:0] daa_adj;
  logic [4:0] daa_nib;
  logic [7:0] szp_val;
  logic       szp_upd;

  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  // Shared adder and subtractor; carry-in used by adc and sbb only.
  always_comb begin
    cin = ((s1.kind == KIND_ADC) || (s1.kind == KIND_SBB)) ? flags.cy : 1'b0;
    add_sum  = {1'b0, acc} + {1'b0, s1.operand} + {8'd0, cin};
    add_nib  = {1'b0, acc[3:0]} + {1'b0, s1.operand[3:0]} + {4'd0, cin};
    sub_diff = {1'b0, acc} - {1'b0, s1.operand} - {8'd0, cin};
    sub_nib  = {1'b0, acc[3:0]} + {1'b0, ~s1.operand[3:0]} + {4'd0, !cin};
    pair_full = {1'b0, s1.pair_left} + {1'b0, s1.pair_right};
    daa_hi = acc[7:4];
    daa_lo = acc[3:0];
    daa_lo_adj = flags.ac || (daa_lo > 4'd9);
    daa_hi_adj = flags.cy || (daa_hi > 4'd9) || ((daa_hi >= 4'd9) && (daa_lo > 4'd9));
    daa_adj = (daa_lo_adj ? DAA_ADJ_LO : 8'h00) | (daa_hi_adj ? DAA_ADJ_HI : 8'h00);
    daa_nib = {1'b0, daa_lo} + {1'b0, daa_adj[3:0]};
  end

  always_comb begin
    acc_next   = acc;
    flags_next = flags;
    byte_next  = 8'h00;
    psum_next  = 16'h0000;
    szp_val    = 8'h00;
    szp_upd    = 1'b0;
    unique case (s1.kind)
      KIND_ADD, KIND_ADC: begin
        acc_next      = add_sum[7:0];
        flags_next.ac = add_nib[4];
        flags_next.cy = add_sum[8];
        szp_val = add_sum[7:0];
        szp_upd = 1'b1;
      end
      KIND_SUB, KIND_SBB, KIND_CMP: begin
        if (s1.kind != KIND_CMP) begin
          acc_next = sub_diff[7:0];
        end
        flags_next.ac = sub_nib[4];
        flags_next.cy = sub_diff[8];
        szp_val = sub_diff[7:0];
        szp_upd = 1'b1;
      end
      KIND_AND: begin
        acc_next      = acc & s1.operand;
        flags_next.cy = 1'b0;
        flags_next.ac = acc[3] | s1.operand[3];
        szp_val = acc & s1.operand;
        szp_upd = 1'b1;
      end
      KIND_XOR, KIND_OR: begin
        acc_next = (s1.kind == KIND_XOR) ? (acc ^ s1.operand) : (acc | s1.operand);
        flags_next.cy = 1'b0;
        flags_next.ac = 1'b0;
        szp_val = acc_next;
        szp_upd = 1'b1;
      end
      KIND_INC: begin
        byte_next     = s1.operand + 8'd1;
        flags_next.ac = (s1.operand[3:0] == 4'hF);
        szp_val = byte_next;
        szp_upd = 1'b1;
      end
      KIND_DEC: begin
        byte_next     = s1.operand - 8'd1;
        flags_next.ac = (s1.operand[3:0] != 4'h0);
        szp_val = byte_next;
        szp_upd = 1'b1;
      end
      KIND_DAA: begin
        acc_next      = acc + daa_adj;
        flags_next.ac = daa_nib[4];
        if (daa_hi_adj) begin
          flags_next.cy = 1'b1;
        end
        szp_val = acc_next;
        szp_upd = 1'b1;
      end
      KIND_RLC: begin
        acc_next      = {acc[6:0], acc[7]};
        flags_next.cy = acc[7];
      end
      KIND_RRC: begin
        acc_next      = {acc[0], acc[7:1]};
        flags_next.cy = acc[0];
      end
      KIND_RAL: begin
        acc_next      = {acc[6:0], flags.cy};
        flags_next.cy = acc[7];
      end
      KIND_RAR: begin
        acc_next      = {flags.cy, acc[7:1]};
        flags_next.cy = acc[0];
      end
      KIND_CMA:       acc_next = ~acc;
      KIND_CMC:       flags_next.cy = !flags.cy;
      KIND_STC:       flags_next.cy = 1'b1;
      KIND_PAIR_ADD: begin
        psum_next     = pair_full[15:0];
        flags_next.cy = pair_full[16];
      end
      KIND_LOAD_ACC:  acc_next = s1.operand;
      KIND_LOAD_FLAG: begin
        flags_next.cy = s1.operand[0];
        flags_next.p  = s1.operand[2];
        flags_next.ac = s1.operand[4];
        flags_next.z  = s1.operand[6];
        flags_next.s  = s1.operand[7];
      end
      default: ;
    endcase
    if (szp_upd) begin
      flags_next.z = (szp_val == 8'h00);
      flags_next.s = szp_val[7];
      flags_next.p = ~^szp_val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
      acc       <= 8'h00;
      flags     <= '0;
    end else begin
      if (in_ready) begin
        s1_valid <= in_valid;
      end
      if (advance) begin
        out_valid <= 1'b1;
        acc       <= acc_next;
        flags     <= flags_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers: input loads on acceptance, result on advance; hold otherwise.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1 <= in_data;
    end
    if (advance) begin
      out_data.acc_out     <= acc_next;
      out_data.status_word <= status_of(flags_next);
      out_data.byte_result <= byte_next;
      out_data.pair_sum    <= psum_next;
    end
  end

  a_acc_matches: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.acc_out == acc))
    else $error("reported accumulator differs from held accumulator");

  a_status_matches: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.status_word == status_of(flags)))
    else $error("reported status word differs from held flags");

  a_state_holds: assert property (@(posedge clk) disable iff (rst)
    !advance |=> ($stable(acc) && $stable(flags)))
    else $error("state changed without a transaction moving to the result");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    (!s1_valid || !out_valid) |-> in_ready)
    else $error("input stalled with a free stage");

endmodule
